@@ src/shat_pkg.sv @@
package shat_pkg;

    localparam int SECTOR_COUNT_DEF  = 24;
    localparam int ROW_COUNT_DEF     = 45;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int W_COORD = 22;
    localparam int W_CRD   = 33;   // CORDIC x, y
    localparam int W_ANG   = 26;   // CORDIC residual angle
    localparam int W_P     = 26;   // point relative to pivot
    localparam int W_O     = 23;   // pivot coordinate

    localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
    localparam logic signed [31:0] Q30_HALF = 32'sd536870912;
    localparam logic signed [31:0] Q30_R3H  = 32'sd929887697;
    localparam logic signed [W_CRD-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [26:0] DEG90  = 27'sd5898240;
    localparam logic signed [26:0] DEG180 = 27'sd11796480;
    localparam logic signed [26:0] DEG360 = 27'sd23592960;

    localparam logic signed [61:0] OUT_MAX = 62'sd2097151;
    localparam logic signed [61:0] OUT_MIN = -62'sd2097152;

    typedef struct packed {
        logic                    bad;
        logic                    neg;
        logic signed [W_P-1:0]   px;
        logic signed [W_P-1:0]   py;
        logic signed [W_O-1:0]   ox;
        logic signed [W_O-1:0]   oy;
        logic signed [W_COORD-1:0] hz;
    } t_pay;

    typedef struct packed {
        logic                    valid;
        logic signed [W_CRD-1:0] x;
        logic signed [W_CRD-1:0] y;
        logic signed [W_ANG-1:0] z;
        t_pay                    pay;
    } t_cell;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_dir;

    function automatic logic signed [W_ANG-1:0] shat_atan(input int i);
        unique case (i)
            0:  return 26'sd2949120;
            1:  return 26'sd1740967;
            2:  return 26'sd919879;
            3:  return 26'sd466945;
            4:  return 26'sd234379;
            5:  return 26'sd117304;
            6:  return 26'sd58666;
            7:  return 26'sd29335;
            8:  return 26'sd14668;
            9:  return 26'sd7334;
            10: return 26'sd3667;
            11: return 26'sd1833;
            12: return 26'sd917;
            13: return 26'sd458;
            14: return 26'sd229;
            15: return 26'sd115;
            16: return 26'sd57;
            17: return 26'sd29;
            18: return 26'sd14;
            19: return 26'sd7;
            20: return 26'sd4;
            21: return 26'sd2;
            22: return 26'sd1;
            default: return 26'sd0;
        endcase
    endfunction

    function automatic t_dir shat_dir(input logic [4:0] k);
        t_dir d;
        unique case (k)
            5'd0:  d = '{Q30_HALF,  Q30_R3H};
            5'd1:  d = '{Q30_R3H,   Q30_HALF};
            5'd2:  d = '{Q30_ONE,   32'sd0};
            5'd3:  d = '{Q30_R3H,  -Q30_HALF};
            5'd4:  d = '{Q30_HALF, -Q30_R3H};
            5'd5:  d = '{32'sd0,   -Q30_ONE};
            5'd6:  d = '{-Q30_HALF, -Q30_R3H};
            5'd7:  d = '{-Q30_R3H, -Q30_HALF};
            5'd8:  d = '{-Q30_ONE,  32'sd0};
            5'd9:  d = '{-Q30_R3H,  Q30_HALF};
            5'd10: d = '{-Q30_HALF, Q30_R3H};
            5'd11: d = '{32'sd0,    Q30_ONE};
            5'd12: d = '{-Q30_HALF, Q30_R3H};
            5'd13: d = '{-Q30_R3H,  Q30_HALF};
            5'd14: d = '{-Q30_ONE,  32'sd0};
            5'd15: d = '{-Q30_R3H, -Q30_HALF};
            5'd16: d = '{-Q30_HALF, -Q30_R3H};
            5'd17: d = '{32'sd0,   -Q30_ONE};
            5'd18: d = '{Q30_HALF, -Q30_R3H};
            5'd19: d = '{Q30_R3H,  -Q30_HALF};
            5'd20: d = '{Q30_ONE,   32'sd0};
            5'd21: d = '{Q30_R3H,   Q30_HALF};
            5'd22: d = '{Q30_HALF,  Q30_R3H};
            5'd23: d = '{32'sd0,    Q30_ONE};
            default: d = '{32'sd0,  32'sd0};
        endcase
        return d;
    endfunction

    // Q30 round half up
    function automatic logic signed [61:0] shat_rnd30(input logic signed [61:0] v);
        return (v + 62'sd536870912) >>> 30;
    endfunction

endpackage

@@ src/shat_cordic_cell.sv @@
module shat_cordic_cell
    import shat_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    localparam logic signed [W_ANG-1:0] ATAN = shat_atan(STAGE);

    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = i_cell;
        if (i_cell.z >= 0) begin
            n_cell.x = i_cell.x - (i_cell.y >>> STAGE);
            n_cell.y = i_cell.y + (i_cell.x >>> STAGE);
            n_cell.z = i_cell.z - ATAN;
        end else begin
            n_cell.x = i_cell.x + (i_cell.y >>> STAGE);
            n_cell.y = i_cell.y - (i_cell.x >>> STAGE);
            n_cell.z = i_cell.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

@@ src/sector_hit_alignment_transform.sv @@
// Sector hit alignment. Each hit transaction (op 0) is moved by its sector's
// radial offset when translation is enabled for its half, then rotated
// clockwise by the calibrated angle about a pivot on the sector axis; z passes
// through, as do x and y of a bad-address hit. A table transaction (op 1)
// writes one calibration entry for a valid sector and produces no result.
// One transaction is accepted per cycle while o_ready is high; a hit's result
// passes one register each for table lookup, offset and pivot multiplies,
// the CORDIC chain of CORDIC_STAGES cells (fed by the pivot subtract),
// rotation multiplies, and round and saturate. The whole pipeline holds while
// a result waits and i_ready is low. The calibration table reads as zero
// (identity) after reset through per-entry valid bits; no clearing pass.
module sector_hit_alignment_transform
    import shat_pkg::*;
#(
    parameter int SECTOR_COUNT  = SECTOR_COUNT_DEF,
    parameter int ROW_COUNT     = ROW_COUNT_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_op,
    input  logic [4:0]          i_sector,
    input  logic [5:0]          i_row,
    input  logic signed [21:0]  i_hit_x,
    input  logic signed [21:0]  i_hit_y,
    input  logic signed [21:0]  i_hit_z,
    input  logic                i_entry_half,
    input  logic signed [24:0]  i_entry_angle,
    input  logic signed [21:0]  i_entry_offset,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [21:0]  o_out_x,
    output logic signed [21:0]  o_out_y,
    output logic signed [21:0]  o_out_z,
    output logic                o_bad_address,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [20:0]         i_cfg_data
);

    localparam int DEPTH = 2 * SECTOR_COUNT;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        REG_LAST_INNER = 2'd0,
        REG_INNER_RAD  = 2'd1,
        REG_OUTER_RAD  = 2'd2,
        REG_TRANS_OUT  = 2'd3
    } t_reg;

    // configuration
    logic [5:0]  r_last_inner;
    logic [20:0] r_inner_rad;
    logic [20:0] r_outer_rad;
    logic        r_trans_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_inner  <= 6'd13;
            r_inner_rad   <= 21'd125952;
            r_outer_rad   <= 21'd125952;
            r_trans_outer <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_LAST_INNER: r_last_inner  <= i_cfg_data[5:0];
                REG_INNER_RAD:  r_inner_rad   <= i_cfg_data;
                REG_OUTER_RAD:  r_outer_rad   <= i_cfg_data;
                REG_TRANS_OUT:  r_trans_outer <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic en;
    logic accept;
    assign en     = !o_valid || i_ready;
    assign o_ready = en;
    assign accept = i_valid && en;

    // decode the incoming transaction
    logic sec_ok;
    logic bad_in;
    logic inner_in;
    logic [4:0] sec_m1;
    logic [IW-1:0] widx;
    logic [IW-1:0] ridx;

    assign sec_m1   = i_sector - 5'd1;
    assign sec_ok   = (i_sector >= 5'd1) && (i_sector <= 5'(SECTOR_COUNT));
    assign bad_in   = !sec_ok || (i_row < 6'd1) || (i_row > 6'(ROW_COUNT));
    assign inner_in = (i_row <= r_last_inner);
    assign widx     = IW'({sec_m1, i_entry_half});
    assign ridx     = bad_in ? '0 : IW'({sec_m1, !inner_in});

    // calibration table: angle and offset, valid bits give the zero reset
    logic [46:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_mem_vld;

    always_ff @(posedge i_clk) begin
        if (accept && i_op && sec_ok) begin
            r_mem[widx] <= {i_entry_angle, i_entry_offset};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (accept && i_op && sec_ok) begin
            r_mem_vld[widx] <= 1'b1;
        end
    end

    // stage A: table read
    logic        r_a_valid;
    logic        r_a_bad;
    logic        r_a_inner;
    logic        r_a_trans;
    logic [4:0]  r_a_sec;
    logic signed [21:0] r_a_hx, r_a_hy, r_a_hz;
    logic [46:0] r_a_ent;
    logic        r_a_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid && !i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_bad   <= bad_in;
            r_a_inner <= inner_in;
            r_a_trans <= inner_in ^ r_trans_outer;
            r_a_sec   <= sec_m1;
            r_a_hx    <= i_hit_x;
            r_a_hy    <= i_hit_y;
            r_a_hz    <= i_hit_z;
            r_a_ent   <= r_mem[ridx];
            r_a_ev    <= r_mem_vld[ridx];
        end
    end

    // stage B: offset and pivot multiplies, angle reduction
    t_dir dir;
    logic signed [21:0] a_off;
    logic signed [24:0] a_ang;
    logic signed [21:0] a_rad;
    logic signed [26:0] ang1;
    logic signed [26:0] ang2;
    logic               a_neg;

    assign dir   = shat_dir(r_a_sec);
    assign a_off = r_a_ev ? $signed(r_a_ent[21:0]) : 22'sd0;
    assign a_ang = r_a_ev ? $signed(r_a_ent[46:22]) : 25'sd0;
    assign a_rad = $signed({1'b0, r_a_inner ? r_inner_rad : r_outer_rad});

    always_comb begin
        ang1 = 27'(a_ang);
        if (ang1 > DEG180) begin
            ang1 = ang1 - DEG360;
        end else if (ang1 < -DEG180) begin
            ang1 = ang1 + DEG360;
        end
        a_neg = 1'b0;
        ang2  = ang1;
        if (ang1 > DEG90) begin
            ang2  = ang1 - DEG180;
            a_neg = 1'b1;
        end else if (ang1 < -DEG90) begin
            ang2  = ang1 + DEG180;
            a_neg = 1'b1;
        end
    end

    logic        r_b_valid;
    logic        r_b_bad;
    logic        r_b_trans;
    logic        r_b_neg;
    logic signed [W_ANG-1:0] r_b_ang;
    logic signed [21:0] r_b_hx, r_b_hy, r_b_hz;
    logic signed [53:0] r_b_osx, r_b_osy, r_b_rsx, r_b_rsy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_bad   <= r_a_bad;
            r_b_trans <= r_a_trans;
            r_b_neg   <= a_neg;
            r_b_ang   <= W_ANG'(ang2);
            r_b_hx    <= r_a_hx;
            r_b_hy    <= r_a_hy;
            r_b_hz    <= r_a_hz;
            r_b_osx   <= 54'(a_off) * 54'(dir.sx);
            r_b_osy   <= 54'(a_off) * 54'(dir.sy);
            r_b_rsx   <= 54'(a_rad) * 54'(dir.sx);
            r_b_rsy   <= 54'(a_rad) * 54'(dir.sy);
        end
    end

    // translate, subtract pivot, feed the CORDIC chain
    logic signed [W_O-1:0] ox, oy;
    logic signed [23:0]    tx, ty;
    t_cell cells [CORDIC_STAGES+1];

    assign ox = W_O'(shat_rnd30(62'(r_b_rsx)));
    assign oy = W_O'(shat_rnd30(62'(r_b_rsy)));
    assign tx = r_b_trans ? 24'(shat_rnd30(-62'(r_b_osy))) : 24'sd0;
    assign ty = r_b_trans ? 24'(shat_rnd30(62'(r_b_osx))) : 24'sd0;

    always_comb begin
        cells[0].valid  = r_b_valid;
        cells[0].x      = CORDIC_GAIN;
        cells[0].y      = '0;
        cells[0].z      = r_b_ang;
        cells[0].pay.bad = r_b_bad;
        cells[0].pay.neg = r_b_neg;
        cells[0].pay.ox  = ox;
        cells[0].pay.oy  = oy;
        cells[0].pay.hz  = r_b_hz;
        if (r_b_bad) begin
            // carry the raw hit for passthrough
            cells[0].pay.px = W_P'(r_b_hx);
            cells[0].pay.py = W_P'(r_b_hy);
        end else begin
            cells[0].pay.px = W_P'(r_b_hx) + W_P'(tx) - W_P'(ox);
            cells[0].pay.py = W_P'(r_b_hy) + W_P'(ty) - W_P'(oy);
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        shat_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_cell (cells[g]),
            .o_cell (cells[g+1])
        );
    end

    // stage D: rotation multiplies
    t_cell c_last;
    logic signed [W_CRD-1:0] c_cos, c_sin;

    assign c_last = cells[CORDIC_STAGES];
    assign c_cos  = c_last.pay.neg ? -c_last.x : c_last.x;
    assign c_sin  = c_last.pay.neg ? -c_last.y : c_last.y;

    logic        r_d_valid;
    logic        r_d_bad;
    logic signed [W_O-1:0] r_d_ox, r_d_oy;
    logic signed [W_P-1:0] r_d_px, r_d_py;
    logic signed [21:0]    r_d_hz;
    logic signed [58:0]    r_d_pxc, r_d_pys, r_d_pyc, r_d_pxs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= c_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_bad <= c_last.pay.bad;
            r_d_ox  <= c_last.pay.ox;
            r_d_oy  <= c_last.pay.oy;
            r_d_px  <= c_last.pay.px;
            r_d_py  <= c_last.pay.py;
            r_d_hz  <= c_last.pay.hz;
            r_d_pxc <= 59'(c_last.pay.px) * 59'(c_cos);
            r_d_pys <= 59'(c_last.pay.py) * 59'(c_sin);
            r_d_pyc <= 59'(c_last.pay.py) * 59'(c_cos);
            r_d_pxs <= 59'(c_last.pay.px) * 59'(c_sin);
        end
    end

    // stage E: round, restore pivot, saturate into the output register
    logic signed [61:0] rx_full, ry_full;
    logic signed [21:0] sat_x, sat_y;

    assign rx_full = shat_rnd30(62'(r_d_pxc) + 62'(r_d_pys)) + 62'(r_d_ox);
    assign ry_full = shat_rnd30(62'(r_d_pyc) - 62'(r_d_pxs)) + 62'(r_d_oy);

    always_comb begin
        if (rx_full > OUT_MAX) begin
            sat_x = 22'(OUT_MAX);
        end else if (rx_full < OUT_MIN) begin
            sat_x = 22'(OUT_MIN);
        end else begin
            sat_x = 22'(rx_full);
        end
        if (ry_full > OUT_MAX) begin
            sat_y = 22'(OUT_MAX);
        end else if (ry_full < OUT_MIN) begin
            sat_y = 22'(OUT_MIN);
        end else begin
            sat_y = 22'(ry_full);
        end
    end

    logic               r_out_valid;
    logic signed [21:0] r_out_x, r_out_y, r_out_z;
    logic               r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x   <= r_d_bad ? 22'(r_d_px) : sat_x;
            r_out_y   <= r_d_bad ? 22'(r_d_py) : sat_y;
            r_out_z   <= r_d_hz;
            r_out_bad <= r_d_bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_z       = r_out_z;
    assign o_bad_address = r_out_bad;

endmodule
